@@ rtl/sndx_pkg.sv @@
// ---------------------------------------------------------------------------
// sndx_pkg: shared types and helpers for the Soundex name encoder
// Item and result records, digit widths and the letter-to-digit mapping.
// ---------------------------------------------------------------------------
package sndx_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CodeW      = 3;
  localparam int unsigned DigitsKept = 3;
  localparam int unsigned CountW     = 2;

  localparam logic [ByteW-1:0] AsciiZero   = 8'h30;
  localparam logic [ByteW-1:0] AsciiNine   = 8'h39;
  localparam logic [ByteW-1:0] AsciiLowerA = 8'h61;
  localparam logic [ByteW-1:0] AsciiLowerZ = 8'h7a;
  localparam logic [ByteW-1:0] CaseOffset  = 8'h20;

  localparam logic [CodeW-1:0] CodeNone = 3'd0;
  localparam logic [CodeW-1:0] CodeLab  = 3'd1;  // B F P V
  localparam logic [CodeW-1:0] CodeGut  = 3'd2;  // C G J K Q S X Z
  localparam logic [CodeW-1:0] CodeDent = 3'd3;  // D T
  localparam logic [CodeW-1:0] CodeLiq  = 3'd4;  // L
  localparam logic [CodeW-1:0] CodeNas  = 3'd5;  // M N
  localparam logic [CodeW-1:0] CodeRho  = 3'd6;  // R

  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             has_char;
    logic             is_last;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] head_letter;
    logic [CodeW-1:0] code_one;
    logic [CodeW-1:0] code_two;
    logic [CodeW-1:0] code_three;
    logic             empty_code;
  } result_t;

  // lower-case ascii letters to upper case, everything else unchanged
  function automatic logic [ByteW-1:0] upcase(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] r;
    r = c;
    if (c >= AsciiLowerA && c <= AsciiLowerZ) begin
      r = c - CaseOffset;
    end
    return r;
  endfunction

  // case-insensitive soundex digit, zero for anything unmapped
  function automatic logic [CodeW-1:0] letter_code(input logic [ByteW-1:0] c);
    logic [CodeW-1:0] r;
    unique case (upcase(c))
      8'h42, 8'h46, 8'h50, 8'h56:                         r = CodeLab;
      8'h43, 8'h47, 8'h4a, 8'h4b, 8'h51, 8'h53, 8'h58, 8'h5a: r = CodeGut;
      8'h44, 8'h54:                                       r = CodeDent;
      8'h4c:                                              r = CodeLiq;
      8'h4d, 8'h4e:                                       r = CodeNas;
      8'h52:                                              r = CodeRho;
      default:                                            r = CodeNone;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/sndx_core.sv @@
// ---------------------------------------------------------------------------
// sndx_core: per-name encoding state
// Folds one byte per advance into the head letter and digit store and
// forms the result that goes out on the last byte of a name.
// ---------------------------------------------------------------------------
module sndx_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  sndx_pkg::item_t  item_i,
  output sndx_pkg::result_t result_o
);
  import sndx_pkg::*;

  logic                  head_seen_q, head_seen_d;
  logic [ByteW-1:0]      head_byte_q, head_byte_d;
  logic [CodeW-1:0]      prior_code_q, prior_code_d;
  logic [CountW-1:0]     digit_count_q, digit_count_d;
  logic [CodeW-1:0]      digit_store_q [DigitsKept];
  logic [CodeW-1:0]      digit_store_d [DigitsKept];
  logic [CodeW-1:0]      code;
  logic                  is_digit;

  assign code     = letter_code(item_i.ch);
  assign is_digit = (item_i.ch >= AsciiZero) && (item_i.ch <= AsciiNine);

  // next state for the byte in the input stage
  always_comb begin
    head_seen_d   = head_seen_q;
    head_byte_d   = head_byte_q;
    prior_code_d  = prior_code_q;
    digit_count_d = digit_count_q;
    digit_store_d = digit_store_q;
    if (item_i.has_char) begin
      if (!head_seen_q) begin
        if (!is_digit) begin
          head_seen_d = 1'b1;
          head_byte_d = upcase(item_i.ch);
        end
      end else if (digit_count_q < CountW'(DigitsKept)) begin
        if (code != CodeNone && code != prior_code_q) begin
          digit_store_d[digit_count_q] = code;
          digit_count_d                = digit_count_q + CountW'(1);
          prior_code_d                 = code;
        end
      end
    end
  end

  // result as seen after this byte
  always_comb begin
    if (head_seen_d) begin
      result_o.head_letter = head_byte_d;
      result_o.code_one    = digit_store_d[0];
      result_o.code_two    = digit_store_d[1];
      result_o.code_three  = digit_store_d[2];
      result_o.empty_code  = 1'b0;
    end else begin
      result_o.head_letter = '0;
      result_o.code_one    = CodeNone;
      result_o.code_two    = CodeNone;
      result_o.code_three  = CodeNone;
      result_o.empty_code  = 1'b1;
    end
  end

  // state registers, cleared after each name
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_seen_q   <= 1'b0;
      head_byte_q   <= '0;
      prior_code_q  <= CodeNone;
      digit_count_q <= '0;
      for (int i = 0; i < DigitsKept; i++) digit_store_q[i] <= CodeNone;
    end else if (advance_i) begin
      if (item_i.is_last) begin
        head_seen_q   <= 1'b0;
        head_byte_q   <= '0;
        prior_code_q  <= CodeNone;
        digit_count_q <= '0;
        for (int i = 0; i < DigitsKept; i++) digit_store_q[i] <= CodeNone;
      end else begin
        head_seen_q   <= head_seen_d;
        head_byte_q   <= head_byte_d;
        prior_code_q  <= prior_code_d;
        digit_count_q <= digit_count_d;
        digit_store_q <= digit_store_d;
      end
    end
  end

  // no digits before a head letter
  a_count_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_seen_q |-> digit_count_q == '0)
    else $error("digits held without head letter");

  // prior code is zero exactly when no digit is held
  a_prior_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digit_count_q == '0) == (prior_code_q == CodeNone))
    else $error("prior code out of step with digit count");

  // state is cleared after the last byte of a name
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.is_last |=> !head_seen_q && digit_count_q == '0)
    else $error("state not cleared after end of name");

endmodule

@@ rtl/soundex_name_encoder_unit.sv @@
// ---------------------------------------------------------------------------
// soundex_name_encoder_unit: streaming Soundex-style name encoder
// Input register, encoding state and result register.
// ---------------------------------------------------------------------------
// Usage:
//   A name enters one byte per transfer on the in_ channel (valid/ready);
//   has_char_i = 0 marks a bare end marker, is_last_i = 1 ends the name.
//   Exactly one result leaves on the out_ channel per name, after the
//   transfer marked is_last_i: head letter, three digits, and empty_code_o
//   set when no head letter was found.
//   Timing: a byte is held in the input register and is folded in when
//   it advances; the result is loaded into the result register when the
//   last byte of the name advances.
//   Throughput: one byte per cycle while no last byte waits on a full
//   result register; a new byte gets in while a finished result waits.
//   Stall: while the result register holds an untaken result, only a last
//   byte waits in the input register; other bytes keep flowing.
//   Reset: valid flags and encoding state clear, no result is pending,
//   the next byte starts a new name.
// ---------------------------------------------------------------------------
module soundex_name_encoder_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [sndx_pkg::ByteW-1:0]            ch_i,
  input  logic                                  has_char_i,
  input  logic                                  is_last_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [sndx_pkg::ByteW-1:0]            head_letter_o,
  output logic [sndx_pkg::CodeW-1:0]            code_one_o,
  output logic [sndx_pkg::CodeW-1:0]            code_two_o,
  output logic [sndx_pkg::CodeW-1:0]            code_three_o,
  output logic                                  empty_code_o
);
  import sndx_pkg::*;

  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t result_q;
  result_t result;
  logic    out_free;
  logic    advance;

  // the input stage moves on unless it holds a last byte and the result slot is full
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!item_q.is_last || out_free);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.ch       <= ch_i;
      item_q.has_char <= has_char_i;
      item_q.is_last  <= is_last_i;
    end
  end

  sndx_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .result_o  (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && item_q.is_last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && item_q.is_last) begin
      result_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign head_letter_o = result_q.head_letter;
  assign code_one_o    = result_q.code_one;
  assign code_two_o    = result_q.code_two;
  assign code_three_o  = result_q.code_three;
  assign empty_code_o  = result_q.empty_code;

  // a finished name always lands in the result register
  a_last_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && item_q.is_last |=> out_valid_q)
    else $error("end of name did not produce a result");

  // a waiting result stays put until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(result_q))
    else $error("result changed while waiting");

  // an empty input register always takes a transfer
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("input not ready while input register is empty");

endmodule
